/* sv/cpbm_pkg.sv */
// Shared types and constants of the cartridge program ROM bank mapper.
// No dependencies; imported by cpbm_bank_ctl and the top level.
`timescale 1ns / 1ps
`default_nettype none

package cpbm_pkg;

    localparam int RAM_BYTES  = 8192;
    localparam int BANK_BYTES = 16384;
    localparam int MAX_BANKS  = 256;

    localparam int RAM_AW  = $clog2(RAM_BYTES);
    localparam int OFS_W   = $clog2(BANK_BYTES);
    localparam int BANK_W  = $clog2(MAX_BANKS);
    localparam int ROM_AW  = 22;
    localparam int ADDR_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 9;
    localparam int KIND_W  = 2;
    localparam int CIDX_W  = 2;

    // mapper kinds
    localparam logic [KIND_W-1:0] KIND_FIXED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MMC1  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UXROM = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_KIND  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_BANKS = 2'd1;

    // bus operations
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // MMC1 serial port
    localparam int SER_BITS = 5;
    localparam int SER_CW   = 3;
    localparam int SER_LOW_W = 4;
    localparam logic [1:0] SER_REG_PRG = 2'd3;

    typedef struct packed {
        logic                accept;
        logic                op;
        logic [ADDR_W-1:0]   addr;
        logic [BYTE_W-1:0]   data;
    } access_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [CNT_W-1:0]    bank_count;
    } cfg_t;

    typedef struct packed {
        logic                rom_read;
        logic [ROM_AW-1:0]   rom_address;
    } rom_t;

endpackage

`default_nettype wire

/* sv/cpbm_bank_ctl.sv */
// Bank state (UxROM latch, MMC1 serial register) and ROM address decode.
// Depends on cpbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpbm_bank_ctl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire cpbm_pkg::access_t acc,
    input  wire cpbm_pkg::cfg_t    cfg,
    output cpbm_pkg::rom_t       rom
);
    import cpbm_pkg::*;

    logic [BANK_W-1:0]    latched_bank_reg, latched_bank_next;
    logic [SER_BITS-1:0]  serial_shift_reg, serial_shift_next;
    logic [SER_CW-1:0]    serial_count_reg, serial_count_next;
    logic [SER_LOW_W-1:0] serial_low_reg,   serial_low_next;

    logic [BANK_W-1:0] last_bank;
    logic [BANK_W-1:0] bank_sel;
    logic [SER_CW-1:0] ser_pos;
    logic [SER_CW-1:0] ser_cnt_inc;
    logic [SER_BITS-1:0] ser_shift_upd;
    logic              in_ram, in_rom, in_high;

    function automatic logic [BANK_W-1:0] clamp(input logic [BANK_W-1:0] b,
                                                input logic [BANK_W-1:0] last);
        return (b > last) ? last : b;
    endfunction

    // count of zero acts as one bank, anything above MAX_BANKS as MAX_BANKS
    always_comb begin
        if (cfg.bank_count == '0) begin
            last_bank = '0;
        end else if (cfg.bank_count > CNT_W'(MAX_BANKS)) begin
            last_bank = BANK_W'(MAX_BANKS - 1);
        end else begin
            last_bank = BANK_W'(cfg.bank_count - CNT_W'(1));
        end
    end

    assign in_ram  = (acc.addr >= 16'h6000) && (acc.addr <= 16'h7FFF);
    assign in_rom  = acc.addr >= 16'h8000;
    assign in_high = acc.addr >= 16'hC000;

    always_comb begin
        if (in_high) begin
            bank_sel = (cfg.kind == KIND_FIXED) ? clamp(BANK_W'(1), last_bank) : last_bank;
        end else begin
            case (cfg.kind)
                KIND_UXROM: bank_sel = clamp(latched_bank_reg, last_bank);
                KIND_MMC1:  bank_sel = clamp(BANK_W'(serial_low_reg), last_bank);
                default:    bank_sel = '0;
            endcase
        end
    end

    always_comb begin
        rom.rom_read    = 1'b0;
        rom.rom_address = '0;
        if (acc.op == OP_READ && !in_ram && in_rom && cfg.kind != KIND_NONE) begin
            rom.rom_read    = 1'b1;
            rom.rom_address = ROM_AW'({bank_sel, acc.addr[OFS_W-1:0]});
        end
    end

    // MMC1 serial write: bit 0 enters at the current count, fifth write commits
    always_comb begin
        ser_pos       = (serial_count_reg >= SER_CW'(SER_BITS)) ? '0 : serial_count_reg;
        ser_cnt_inc   = ser_pos + SER_CW'(1);
        ser_shift_upd = serial_shift_reg;
        ser_shift_upd[ser_pos] = serial_shift_reg[ser_pos] | acc.data[0];
    end

    always_comb begin
        latched_bank_next = latched_bank_reg;
        serial_shift_next = serial_shift_reg;
        serial_count_next = serial_count_reg;
        serial_low_next   = serial_low_reg;
        if (acc.accept && acc.op == OP_WRITE) begin
            if (cfg.kind == KIND_UXROM && in_rom) begin
                latched_bank_next = clamp(acc.data, last_bank);
            end else if (cfg.kind == KIND_MMC1 && !in_ram && in_rom) begin
                if (acc.data[7]) begin
                    serial_shift_next = '0;
                    serial_count_next = '0;
                end else if (ser_cnt_inc == SER_CW'(SER_BITS)) begin
                    if (acc.addr[14:13] == SER_REG_PRG) begin
                        serial_low_next = ser_shift_upd[SER_LOW_W-1:0];
                    end
                    serial_shift_next = '0;
                    serial_count_next = '0;
                end else begin
                    serial_shift_next = ser_shift_upd;
                    serial_count_next = ser_cnt_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latched_bank_reg <= '0;
            serial_shift_reg <= '0;
            serial_count_reg <= '0;
            serial_low_reg   <= '0;
        end else begin
            latched_bank_reg <= latched_bank_next;
            serial_shift_reg <= serial_shift_next;
            serial_count_reg <= serial_count_next;
            serial_low_reg   <= serial_low_next;
        end
    end

endmodule

`default_nettype wire

/* sv/cartridge_prg_bank_mapper_unit.sv */
// Top level of the cartridge program ROM bank mapper: work RAM, config, output stage.
// Depends on cpbm_pkg and cpbm_bank_ctl.
`timescale 1ns / 1ps
`default_nettype none

// One bus access per item, one item per cycle unless a held result stalls the input.
// An accepted item reads the 8 KB work RAM (single-port synchronous array) at the
// accept edge, and writes it only in MMC1 mode; it decodes the ROM address from the
// bank state in the same cycle, and the result is registered into the output stage at
// that edge. A new item is taken whenever the output stage is empty or being drained.
// Work RAM bytes read before they were ever written return undefined data. Configuration
// writes (index 0 mapper kind, 1 bank count) are taken every cycle; others are ignored.
module cartridge_prg_bank_mapper_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // bus_address[15:0], write_byte[23:16]
    input  wire logic        s_tuser,   // operation
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // rom_address[21:0], read_data[29:22], zero pad
    output logic             m_tuser,   // rom_read
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [cpbm_pkg::CIDX_W-1:0] cfg_index,
    input  wire logic [cpbm_pkg::CNT_W-1:0]  cfg_data
);
    import cpbm_pkg::*;

    logic [BYTE_W-1:0] work_ram [RAM_BYTES];

    logic [KIND_W-1:0] kind_reg;
    logic [CNT_W-1:0]  count_reg;

    logic              out_valid_reg, out_valid_next;
    logic              rom_read_reg;
    logic [ROM_AW-1:0] rom_addr_reg;
    logic              ram_rd_reg;
    logic [BYTE_W-1:0] ram_dout_reg;

    logic              s_accept;
    logic              ram_hit;
    logic [RAM_AW-1:0] ram_idx;
    access_t           acc;
    cfg_t              cfg;
    rom_t              rom;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;

    assign acc.accept = s_accept;
    assign acc.op     = s_tuser;
    assign acc.addr   = s_tdata[ADDR_W-1:0];
    assign acc.data   = s_tdata[ADDR_W+BYTE_W-1:ADDR_W];
    assign cfg.kind       = kind_reg;
    assign cfg.bank_count = count_reg;

    assign ram_hit = (acc.addr >= 16'h6000) && (acc.addr <= 16'h7FFF);
    // 0x6000 has its low 13 bits clear, so the offset is just the low address bits
    assign ram_idx = acc.addr[RAM_AW-1:0];

    cpbm_bank_ctl u_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .acc     (acc),
        .cfg     (cfg),
        .rom     (rom)
    );

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (acc.op == OP_WRITE && ram_hit && kind_reg == KIND_MMC1) begin
                work_ram[ram_idx] <= acc.data;
            end
            ram_dout_reg <= work_ram[ram_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg  <= KIND_FIXED;
            count_reg <= CNT_W'(2);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_KIND:  kind_reg  <= cfg_data[KIND_W-1:0];
                CFG_BANKS: count_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (s_accept) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rom_read_reg <= rom.rom_read;
            rom_addr_reg <= rom.rom_address;
            ram_rd_reg   <= (acc.op == OP_READ) && ram_hit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = rom_read_reg;
    assign m_tdata  = {2'b00, (ram_rd_reg ? ram_dout_reg : BYTE_W'(0)), rom_addr_reg};

    // input side only stalls behind a held result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a held result");

    // a bus write yields an all-zero result
    a_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == OP_WRITE) |=> (m_tuser == 1'b0 && m_tdata == '0))
        else $error("write produced a nonzero result");

    // ROM and RAM results are exclusive
    a_rom_ram_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[29:22] == '0 && !ram_rd_reg))
        else $error("ROM result carries RAM data");

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Testbench for cartridge_prg_bank_mapper_unit: directed and random CPU bus accesses,
// each result item checked in order against an in-bench mapper model. Uses cpbm_pkg.

module testbench;
    import cpbm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int IDLE_PCT       = 7;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 48;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wbyte;
    } bus_access_t;

    typedef struct packed {
        logic              rom_read;
        logic [ROM_AW-1:0] rom_address;
        logic [BYTE_W-1:0] read_data;
    } map_result_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [23:0]        s_tdata   = '0;   // bus_address[15:0], write_byte[23:16]
    logic               s_tuser   = 1'b0; // operation
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [31:0]        m_tdata;          // rom_address[21:0], read_data[29:22], zero pad
    logic               m_tuser;          // rom_read
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_index = '0;
    logic [CNT_W-1:0]   cfg_data  = '0;

    // mapper model state
    logic [BYTE_W-1:0]    ram_model [RAM_BYTES];
    bit                   ram_written [RAM_BYTES];
    int unsigned          written_idx[$];
    logic [BANK_W-1:0]    uxrom_bank = '0;
    logic [SER_BITS-1:0]  ser_shift  = '0;
    logic [SER_CW-1:0]    ser_count  = '0;
    logic [SER_LOW_W-1:0] mmc1_bank  = '0;
    logic [KIND_W-1:0]    cur_kind   = KIND_FIXED;
    logic [CNT_W-1:0]     cur_banks  = CNT_W'(2);

    map_result_t expected_results[$];
    int          errors      = 0;
    int          idle_cycles = 0;
    bit          calm        = 1'b0;
    bit          hold_req    = 1'b0;

    cartridge_prg_bank_mapper_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [BANK_W-1:0] last_bank();
        int n;
        n = cur_banks;
        if (n == 0) n = 1;
        if (n > MAX_BANKS) n = MAX_BANKS;
        return BANK_W'(n - 1);
    endfunction

    function automatic logic [BANK_W-1:0] clamp_bank(int b);
        logic [BANK_W-1:0] lb;
        lb = last_bank();
        return (b > lb) ? lb : BANK_W'(b);
    endfunction

    // Updates the model for one accepted access and returns its result item.
    function automatic map_result_t map_access(bus_access_t a);
        map_result_t       r;
        logic [RAM_AW-1:0] idx;
        logic [BANK_W-1:0] bank;
        bit                ram_area;
        r = '0;
        ram_area = (a.addr >= 16'h6000) && (a.addr <= 16'h7FFF);
        idx = RAM_AW'(a.addr - 16'h6000);
        if (a.op == OP_WRITE) begin
            if (cur_kind == KIND_UXROM && a.addr >= 16'h8000) begin
                uxrom_bank = clamp_bank(a.wbyte);
            end else if (cur_kind == KIND_MMC1) begin
                if (ram_area) begin
                    ram_model[idx] = a.wbyte;
                    if (!ram_written[idx]) begin
                        ram_written[idx] = 1'b1;
                        written_idx.push_back(idx);
                    end
                end else if (a.addr >= 16'h8000) begin
                    if (a.wbyte[7]) begin
                        ser_shift = '0;
                        ser_count = '0;
                    end else begin
                        ser_shift = ser_shift | (SER_BITS'(a.wbyte[0]) << ser_count);
                        ser_count = ser_count + 1'b1;
                        if (ser_count == SER_BITS) begin
                            if (a.addr[14:13] == SER_REG_PRG)
                                mmc1_bank = ser_shift[SER_LOW_W-1:0];
                            ser_shift = '0;
                            ser_count = '0;
                        end
                    end
                end
            end
        end else if (ram_area) begin
            r.read_data = ram_model[idx];
        end else if (a.addr >= 16'h8000 && cur_kind != KIND_NONE) begin
            if (a.addr >= 16'hC000)
                bank = (cur_kind == KIND_FIXED) ? clamp_bank(1) : last_bank();
            else if (cur_kind == KIND_UXROM)
                bank = clamp_bank(uxrom_bank);
            else if (cur_kind == KIND_MMC1)
                bank = clamp_bank(mmc1_bank);
            else
                bank = '0;
            r.rom_read    = 1'b1;
            r.rom_address = {bank, a.addr[OFS_W-1:0]};
        end
        return r;
    endfunction

    function automatic bus_access_t random_access();
        bus_access_t a;
        int          pick;
        a.op    = OP_READ;
        a.addr  = 16'($urandom);
        a.wbyte = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 30) begin
            a.addr = 16'h8000 | 16'($urandom_range(16'h7FFF));
        end else if (pick < 42) begin
            if (written_idx.size() != 0)
                a.addr = 16'(16'h6000 + written_idx[$urandom_range(written_idx.size() - 1)]);
        end else if (pick < 52) begin
            a.op   = OP_WRITE;
            a.addr = 16'h6000 | 16'($urandom_range(16'h1FFF));
        end else if (pick < 80) begin
            // serial port / bank latch writes, mostly to the PRG register
            a.op   = OP_WRITE;
            a.addr = 16'h8000 | 16'($urandom_range(16'h7FFF));
            if ($urandom_range(2) != 0) a.addr[14:13] = SER_REG_PRG;
            if ($urandom_range(11) != 0) a.wbyte[7] = 1'b0;
        end else if (pick < 90) begin
            a.op   = 1'($urandom);
            a.addr = 16'($urandom_range(16'h5FFF));
        end else begin
            a.op = 1'($urandom);
        end
        // never read a work RAM byte that was not written: move it to ROM space
        if (a.op == OP_READ && a.addr >= 16'h6000 && a.addr <= 16'h7FFF
                && !ram_written[RAM_AW'(a.addr - 16'h6000)])
            a.addr[15] = 1'b1;
        return a;
    endfunction

    task automatic send_access(input logic op, input logic [ADDR_W-1:0] addr,
                               input logic [BYTE_W-1:0] wbyte);
        bus_access_t a;
        a.op    = op;
        a.addr  = addr;
        a.wbyte = wbyte;
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {wbyte, addr};
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(map_access(a));
    endtask

    task automatic send_random();
        bus_access_t a;
        a = random_access();
        send_access(a.op, a.addr, a.wbyte);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_KIND) cur_kind = val[KIND_W-1:0];
        else if (idx == CFG_BANKS) cur_banks = val;
    endtask

    // upper data bits of the kind write are don't-care
    task automatic set_mapping(input logic [KIND_W-1:0] kind, input logic [CNT_W-1:0] banks);
        write_reg(CFG_KIND, {7'($urandom), kind});
        write_reg(CFG_BANKS, banks);
    endtask

    task automatic test_fixed_decode();
        // reset mapping: fixed kind, two banks
        send_access(OP_READ, 16'h0000, 8'hFF);
        send_access(OP_READ, 16'h5FFF, 8'h00);
        send_access(OP_READ, 16'h8000, 8'h00);
        send_access(OP_READ, 16'hFFFF, 8'h00);
        send_access(OP_WRITE, 16'h6000, 8'hA5);   // RAM write ignored outside MMC1
        send_access(OP_WRITE, 16'h8000, 8'hFF);
        set_mapping(KIND_FIXED, CNT_W'(1));
        send_access(OP_READ, 16'hC123, 8'h00);    // single bank mirrored high
    endtask

    task automatic test_mmc1_serial();
        set_mapping(KIND_MMC1, CNT_W'(16));
        send_access(OP_WRITE, 16'h6000, 8'hFF);
        send_access(OP_WRITE, 16'h7FFF, 8'h00);
        send_access(OP_READ, 16'h6000, 8'h00);
        send_access(OP_READ, 16'h7FFF, 8'hFF);
        send_access(OP_WRITE, 16'h8000, 8'h01);   // partial sequence, then clear
        send_access(OP_WRITE, 16'h8000, 8'h81);
        send_access(OP_WRITE, 16'hE000, 8'h01);
        send_access(OP_WRITE, 16'hE000, 8'h00);
        send_access(OP_WRITE, 16'hE000, 8'h01);
        send_access(OP_WRITE, 16'hE000, 8'h00);
        send_access(OP_WRITE, 16'hFFFF, 8'hFF & 8'h7F);
        send_access(OP_READ, 16'hBFFF, 8'h00);
    endtask

    task automatic test_uxrom_latch();
        set_mapping(KIND_UXROM, CNT_W'(4));
        send_access(OP_WRITE, 16'hC000, 8'hFF);   // saturates to last bank
        send_access(OP_READ, 16'h8000, 8'h00);
        send_access(OP_WRITE, 16'h8000, 8'h01);
        send_access(OP_READ, 16'hBFFF, 8'h00);
    endtask

    task automatic test_unused_kind();
        set_mapping(KIND_NONE, CNT_W'(2));
        send_access(OP_READ, 16'h8000, 8'h00);
        send_access(OP_READ, 16'h6000, 8'h00);
        send_access(OP_WRITE, 16'hE000, 8'h00);
    endtask

    task automatic test_random_mix();
        logic [KIND_W-1:0] kinds [PHASES];
        logic [CNT_W-1:0]  counts [PHASES];
        kinds  = '{KIND_MMC1, KIND_UXROM, KIND_FIXED, KIND_MMC1, KIND_UXROM, KIND_MMC1,
                   KIND_FIXED, KIND_UXROM, KIND_NONE, KIND_MMC1, KIND_FIXED, KIND_UXROM};
        counts = '{9'd16, 9'd8, 9'd1, 9'd1, 9'd256, 9'd511,
                   9'd0, 9'd300, 9'd5, 9'd3, 9'd256, 9'd2};
        for (int p = 0; p < PHASES; p++) begin
            if (p % 2 == 0)
                write_reg(CIDX_W'($urandom_range(2, 3)), CNT_W'($urandom));  // no such reg
            set_mapping(kinds[p], counts[p]);
            calm = (p == 3);
            repeat (PHASE_ITEMS) send_random();
        end
        calm = 1'b0;
    endtask

    task automatic test_backpressure();
        set_mapping(KIND_MMC1, CNT_W'(12));
        hold_req = 1'b1;
        repeat (40) send_random();
    endtask

    // result side ready: random stalls, none while calm, one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin
        map_result_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got.rom_read    = m_tuser;
            got.rom_address = m_tdata[21:0];
            got.read_data   = m_tdata[29:22];
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result item: rom_read %0d rom_address %h read_data %h",
                         $time, got.rom_read, got.rom_address, got.read_data);
            end else begin
                exp_r = expected_results.pop_front();
                if (got.rom_read !== exp_r.rom_read) begin
                    errors++;
                    $display("%0t: rom_read expected %0d actual %0d",
                             $time, exp_r.rom_read, got.rom_read);
                end
                if (got.rom_address !== exp_r.rom_address) begin
                    errors++;
                    $display("%0t: rom_address expected %h actual %h",
                             $time, exp_r.rom_address, got.rom_address);
                end
                if (got.read_data !== exp_r.read_data) begin
                    errors++;
                    $display("%0t: read_data expected %h actual %h",
                             $time, exp_r.read_data, got.read_data);
                end
            end
        end
    end

    // watchdog: cycles without any accepted item or register write
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_fixed_decode();
        test_mmc1_serial();
        test_uxrom_latch();
        test_unused_kind();
        test_random_mix();
        test_backpressure();
        drain_results();
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
